// ===== sv/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

  localparam int NUM_ORDERS_DEF     = 32;
  localparam int SMALLEST_ORDER_DEF = 3;

  // Highest order an offset of OFFSET_W bits can describe
  localparam int ORDER_LIMIT = 30;
  localparam int OFFSET_W    = 30;

  // Sizes are rounded up to this many low bits (8-byte granules)
  localparam int ALIGN_BITS = 3;

  localparam int SIZE_W   = 31;
  localparam int ADDR_W   = 32;
  localparam int HORDER_W = 5;
  localparam int BYTES_W  = 8;
  localparam int PADDR_W  = 4;

  localparam logic [HORDER_W-1:0] HEAP_ORDER_RST = 5'd16;
  localparam logic [BYTES_W-1:0]  OVERHEAD_RST   = 8'd16;
  localparam logic [BYTES_W-1:0]  HEADER_RST     = 8'd8;

  typedef enum logic [1:0] {
    REG_HEAP_ORDER = 2'd0,
    REG_HEAP_BASE  = 2'd1,
    REG_OVERHEAD   = 2'd2,
    REG_HEADER     = 2'd3
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== sv/buddy_block_allocator_top.sv =====
// Buddy block allocator, allocation only.
// A request passes through the input register and then the result register.
// Throughput: one request per cycle unless the result register is stalled; the order
// search and all splits of a request resolve in one pass between the two registers.
// Reset: asynchronous, active low; free lists empty, heap placed on first request,
// registers at their reset values. No clearing pass.
`default_nettype none

module buddy_block_allocator_top
  import bba_pkg::*;
#(
  parameter int NUM_ORDERS     = NUM_ORDERS_DEF,
  parameter int SMALLEST_ORDER = SMALLEST_ORDER_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,

  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [PADDR_W-1:0]   paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready,

  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire [SIZE_W-1:0]    payload_bytes_i,

  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                granted_o,
  output logic [ADDR_W-1:0]   payload_address_o,
  output logic [HORDER_W-1:0] block_order_o
);

  localparam int OW      = $clog2(NUM_ORDERS);
  localparam int TOP_MAX = (ORDER_LIMIT < NUM_ORDERS - 1) ? ORDER_LIMIT : NUM_ORDERS - 1;
  localparam int TOTAL_W = SIZE_W + 2;
  localparam int NEED_W  = 6;

  localparam logic [HORDER_W-1:0] TOP_MAX_H = HORDER_W'(TOP_MAX);
  localparam logic [NEED_W-1:0]   SMALL_N   = NEED_W'(SMALLEST_ORDER);

  // Configuration registers
  logic [HORDER_W-1:0] heap_order_q;
  logic [ADDR_W-1:0]   heap_base_q;
  logic [BYTES_W-1:0]  overhead_q;
  logic [BYTES_W-1:0]  header_q;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_HEAP_ORDER: prdata = {{(32-HORDER_W){1'b0}}, heap_order_q};
      REG_HEAP_BASE:  prdata = heap_base_q;
      REG_OVERHEAD:   prdata = {{(32-BYTES_W){1'b0}}, overhead_q};
      REG_HEADER:     prdata = {{(32-BYTES_W){1'b0}}, header_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_order_q <= HEAP_ORDER_RST;
      heap_base_q  <= '0;
      overhead_q   <= OVERHEAD_RST;
      header_q     <= HEADER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HEAP_ORDER: heap_order_q <= pwdata[HORDER_W-1:0];
        REG_HEAP_BASE:  heap_base_q  <= pwdata;
        REG_OVERHEAD:   overhead_q   <= pwdata[BYTES_W-1:0];
        REG_HEADER:     header_q     <= pwdata[BYTES_W-1:0];
      endcase
    end
  end

  // Input register
  logic              in_valid_q;
  logic [SIZE_W-1:0] size_q;
  logic              proc_fire;

  assign proc_fire  = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      size_q <= payload_bytes_i;
    end
  end

  // Free lists: one block per order at most
  logic                  heap_ready_q;
  logic [OW-1:0]         top_q;
  logic [ADDR_W-1:0]     base_q;
  logic [NUM_ORDERS-1:0] free_valid_q;
  logic [OFFSET_W-1:0]   free_off_q [NUM_ORDERS];

  logic [OW-1:0]         top_sat;
  logic [OW-1:0]         top_eff;
  logic [ADDR_W-1:0]     base_eff;
  logic [NUM_ORDERS-1:0] valid_eff;

  logic [SIZE_W:0]       size_rnd;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W-1:0]    total_m1;
  logic [NEED_W-1:0]     need;
  logic [NEED_W-1:0]     order;
  logic                  fail_size;
  logic [NUM_ORDERS-1:0] cand;
  logic                  found;
  logic [OW-1:0]         hit;
  logic                  grant;
  logic [OFFSET_W-1:0]   off;

  logic [NUM_ORDERS-1:0] valid_d;
  logic [OFFSET_W-1:0]   off_d [NUM_ORDERS];
  logic [ADDR_W-1:0]     addr_d;

  always_comb begin
    if (heap_order_q > TOP_MAX_H) begin
      top_sat = OW'(TOP_MAX);
    end else begin
      top_sat = heap_order_q[OW-1:0];
    end
  end

  // Before placement the whole heap stands as the free block at the top order
  always_comb begin
    if (heap_ready_q) begin
      top_eff   = top_q;
      base_eff  = base_q;
      valid_eff = free_valid_q;
    end else begin
      top_eff   = top_sat;
      base_eff  = heap_base_q;
      valid_eff = '0;
      valid_eff[top_sat] = 1'b1;
    end
  end

  always_comb begin
    size_rnd = {1'b0, size_q} + (SIZE_W+1)'((1 << ALIGN_BITS) - 1);
    size_rnd[ALIGN_BITS-1:0] = '0;
    total    = {1'b0, size_rnd} + TOTAL_W'(overhead_q);
    total_m1 = total - TOTAL_W'(1);
    need     = '0;
    if (total > TOTAL_W'(1)) begin
      for (int i = 0; i < TOTAL_W; i++) begin
        if (total_m1[i]) need = NEED_W'(i + 1);
      end
    end
    order     = (need > SMALL_N) ? need : SMALL_N;
    fail_size = order > NEED_W'(top_eff);
  end

  // Find the lowest free order in [order, top]
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      cand[i] = valid_eff[i] && (i >= int'(order)) && (i <= int'(top_eff));
    end
    for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        hit   = OW'(i);
      end
    end
    grant = found && !fail_size;
    off   = heap_ready_q ? free_off_q[hit] : '0;
  end

  // Split down: every order between the wanted one and the hit gets its right half
  always_comb begin
    valid_d = valid_eff;
    for (int i = 0; i < NUM_ORDERS; i++) begin
      off_d[i] = free_off_q[i];
    end
    if (!heap_ready_q) begin
      off_d[top_sat] = '0;
    end
    if (grant) begin
      valid_d[hit] = 1'b0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        if (i >= int'(order) && i < int'(hit)) begin
          valid_d[i] = 1'b1;
          off_d[i]   = off + (OFFSET_W'(1) << i);
        end
      end
    end
    addr_d = base_eff + ADDR_W'(off) + ADDR_W'(header_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_ready_q <= 1'b0;
      top_q        <= '0;
      base_q       <= '0;
      free_valid_q <= '0;
    end else if (proc_fire) begin
      heap_ready_q <= 1'b1;
      top_q        <= top_eff;
      base_q       <= base_eff;
      free_valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      for (int i = 0; i < NUM_ORDERS; i++) begin
        free_off_q[i] <= off_d[i];
      end
    end
  end

  // Result register
  logic                out_valid_q;
  logic                granted_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [HORDER_W-1:0] order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      granted_q <= grant;
      addr_q    <= grant ? addr_d : '0;
      order_q   <= grant ? order[HORDER_W-1:0] : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign granted_o         = granted_q;
  assign payload_address_o = addr_q;
  assign block_order_o     = order_q;

  // Orders above the placed top never hold a free block
  logic [NUM_ORDERS-1:0] above_top;

  always_comb begin
    for (int i = 0; i < NUM_ORDERS; i++) begin
      above_top[i] = i > int'(top_q);
    end
  end

  a_no_block_above_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_ready_q |-> ((free_valid_q & above_top) == '0))
    else $error("free block above top order");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (payload_address_o == '0 && block_order_o == '0))
    else $error("failed result carries nonzero fields");

  a_min_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> (block_order_o >= HORDER_W'(SMALLEST_ORDER)))
    else $error("granted block below smallest order");

  a_placed_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire |=> heap_ready_q)
    else $error("heap not placed after first request");

endmodule

`default_nettype wire
